// File: sv/rbws_pkg.sv
// Package for the ring buffer window statistics block.
// Holds the ring depth, the item and result structs and the command codes; no dependencies.
`default_nettype none
package rbws_pkg;

  // Result field widths (free count 5 bits, positions 4 bits) are sized for this depth
  localparam int DEPTH = 16;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_STATS = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] sample;
  } item_t;

  typedef struct packed {
    logic signed [15:0] pop_value;
    logic               pop_empty;
    logic signed [23:0] average_fixed;
    logic signed [15:0] maximum;
    logic signed [15:0] minimum;
    logic signed [15:0] mode_value;
    logic signed [15:0] median_value;
    logic [4:0]         free_count;
    logic [3:0]         write_position;
    logic [3:0]         read_position;
  } result_t;

endpackage
`default_nettype wire

// File: sv/rbws_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module rbws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: sv/ring_buffer_window_statistics_top.sv
// Ring buffer with overwrite and window statistics over all slots.
// Statistics run DEPTH passes of DEPTH pair compares (mode count and median rank)
// through the one read port; a pop reads its slot through the same port.
// busy falls with done, so a new item is taken only once the last result is out; results cannot be stalled.
// Reset (rst, synchronous): pointers zero, DEPTH free, then a clearing pass over
// every slot of the store with busy high.
`default_nettype none
module ring_buffer_window_statistics_top (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire rbws_pkg::item_t item,
  output logic                 busy,
  output logic                 done,
  output rbws_pkg::result_t    result
);
  import rbws_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = 16 + CW + 8;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEP = CW'(DEPTH);
  localparam logic [CW-1:0] MID_LO = CW'((DEPTH - 1) / 2);
  localparam logic [CW-1:0] MID_HI = CW'(DEPTH / 2);

  // Mode and sort both use pair compares: for outer slot i, read i (A),
  // then read each j (B), counting equal and less/equal-rank.
  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_RD    = 9'b000000100,
    S_POPW  = 9'b000001000,
    S_IRD   = 9'b000010000,
    S_ILAT  = 9'b000100000,
    S_JRD   = 9'b001000000,
    S_JEND  = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t state;
  logic [AW-1:0] wptr, rptr, i, j, addr;
  logic [CW-1:0] free_cnt, eq_cnt, lt_cnt, best;
  logic          we, jvalid, first;
  logic [15:0]   wdata, rdata;
  logic signed [15:0] a, mx, mn, mode, med_lo, med_hi, popv;
  logic signed [SW-1:0] sum;
  logic          empty;
  logic [1:0]    cmd;
  logic signed [SW-1:0] scaled, avg;
  logic signed [16:0] msum;

  rbws_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  always_comb begin
    we = 1'b0;
    wdata = 16'(item.sample);
    addr = i;
    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
        wdata = '0;
      end
      S_IDLE: begin
        addr = (item.command == CMD_POP) ? rptr : wptr;
        we = start && item.command == CMD_PUSH;
      end
      // hold the popped slot on the read port
      S_RD: addr = rptr;
      S_IRD: addr = i;
      S_JRD: addr = j;
      default: addr = i;
    endcase
  end

  assign busy = state != S_IDLE;
  assign scaled = sum <<< 8;
  // divide by DEPTH (a power of two), truncating toward zero
  assign avg = scaled / SW'(DEPTH);
  assign msum = 17'(med_lo) + 17'(med_hi);

  // sample b = rdata vs a: count equal, and rank of a = #b<a + #(b==a, j<i)
  logic signed [15:0] b;
  assign b = rdata;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      wptr <= '0;
      rptr <= '0;
      free_cnt <= DEP;
      i <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          i <= i + 1'b1;
          if (i == LAST) begin
            i <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: if (start) begin
          cmd <= item.command;
          popv <= -16'sd1;
          empty <= 1'b0;
          unique case (item.command)
            CMD_PUSH: begin
              wptr <= (wptr == LAST) ? '0 : wptr + 1'b1;
              if (free_cnt <= CW'(1)) begin
                free_cnt <= '0;
                rptr <= (wptr == LAST) ? '0 : wptr + 1'b1;
              end else free_cnt <= free_cnt - 1'b1;
              state <= S_FIN;
            end
            CMD_POP: begin
              if (free_cnt < DEP) state <= S_RD;
              else begin
                empty <= 1'b1;
                state <= S_FIN;
              end
            end
            CMD_STATS: begin
              i <= '0;
              sum <= '0;
              best <= '0;
              first <= 1'b1;
              state <= S_IRD;
            end
            default: state <= S_FIN;
          endcase
        end
        S_RD: state <= S_POPW;
        S_POPW: begin
          popv <= rdata;
          rptr <= (rptr == LAST) ? '0 : rptr + 1'b1;
          free_cnt <= free_cnt + 1'b1;
          state <= S_FIN;
        end
        S_IRD: state <= S_ILAT;
        S_ILAT: begin
          a <= rdata;
          sum <= sum + SW'($signed(rdata));
          if (first) begin
            mx <= rdata;
            mn <= rdata;
          end else begin
            if ($signed(rdata) > mx) mx <= rdata;
            if ($signed(rdata) < mn) mn <= rdata;
          end
          first <= 1'b0;
          j <= '0;
          jvalid <= 1'b0;
          eq_cnt <= '0;
          lt_cnt <= '0;
          state <= S_JRD;
        end
        S_JRD: begin
          // rdata holds slot j-1 when jvalid
          if (jvalid) begin
            if (b == a && j - 1'b1 != i) eq_cnt <= eq_cnt + 1'b1;
            if (b < a || (b == a && j - 1'b1 < i)) lt_cnt <= lt_cnt + 1'b1;
          end
          jvalid <= 1'b1;
          j <= j + 1'b1;
          if (jvalid && j == '0) state <= S_JEND;
          else if (j == LAST) state <= S_JEND;
        end
        S_JEND: begin
          logic [CW-1:0] e, l;
          e = eq_cnt;
          l = lt_cnt;
          if (b == a && LAST != i) e = e + 1'b1;
          if (b < a || (b == a && LAST < i)) l = l + 1'b1;
          if (e >= best) begin
            best <= e;
            mode <= a;
          end
          if (l == MID_LO) med_lo <= a;
          if (l == MID_HI) med_hi <= a;
          i <= i + 1'b1;
          state <= (i == LAST) ? S_FIN : S_IRD;
        end
        S_FIN: begin
          done <= 1'b1;
          result.pop_value <= popv;
          result.pop_empty <= empty;
          result.free_count <= 5'(free_cnt);
          result.write_position <= 4'(wptr);
          result.read_position <= 4'(rptr);
          if (cmd == CMD_STATS) begin
            result.average_fixed <= 24'(avg);
            result.maximum <= mx;
            result.minimum <= mn;
            result.mode_value <= mode;
            result.median_value <= (DEPTH % 2 == 0) ? 16'(msum / 2) : med_hi;
          end else begin
            result.average_fixed <= '0;
            result.maximum <= '0;
            result.minimum <= '0;
            result.mode_value <= '0;
            result.median_value <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_free_range: assert property (@(posedge clk) disable iff (rst)
    free_cnt <= DEP) else $error("free count above depth");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("done outside idle");
  a_full_ptrs: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && free_cnt == '0) |-> wptr == rptr)
    else $error("full ring with split pointers");
endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for ring_buffer_window_statistics_top.
// Drives push/pop/statistics and undefined-command items, predicts each result, compares the whole result.
// Depends on rbws_pkg (DEPTH, item_t, result_t, cmd_t).
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rbws_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   item = '0;
  logic    busy;
  logic    done;
  result_t result;

  ring_buffer_window_statistics_top DUT (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .done(done), .result(result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow state of the ring
  logic signed [15:0] ring_slots [DEPTH];
  logic [3:0] wr_ptr, rd_ptr;
  logic [4:0] ring_free;
  result_t expected_results [$];
  int mismatches = 0;
  int cycles = 0;

  function automatic result_t predict_ring(item_t it);
    result_t r;
    logic signed [15:0] sorted [DEPTH];
    logic signed [15:0] key;
    longint sum;
    int best, cnt, j;
    r = '0;
    r.pop_value = -16'sd1;
    case (it.command)
      CMD_PUSH: begin
        ring_slots[wr_ptr] = it.sample;
        if (ring_free > 0) ring_free--;
        wr_ptr = wr_ptr + 4'd1;
        if (ring_free == 0) rd_ptr = wr_ptr;
      end
      CMD_POP: begin
        if (ring_free < DEPTH) begin
          r.pop_value = ring_slots[rd_ptr];
          rd_ptr = rd_ptr + 4'd1;
          ring_free++;
        end else begin
          r.pop_empty = 1'b1;
        end
      end
      CMD_STATS: begin
        sum = 0;
        best = 0;
        r.maximum = ring_slots[0];
        r.minimum = ring_slots[0];
        r.mode_value = ring_slots[0];
        for (int i = 0; i < DEPTH; i++) begin
          cnt = 0;
          sum += ring_slots[i];
          if (ring_slots[i] > r.maximum) r.maximum = ring_slots[i];
          if (ring_slots[i] < r.minimum) r.minimum = ring_slots[i];
          for (int k = 0; k < DEPTH; k++)
            if (k != i && ring_slots[k] == ring_slots[i]) cnt++;
          if (cnt >= best) begin
            best = cnt;
            r.mode_value = ring_slots[i];
          end
        end
        r.average_fixed = 24'((sum * 256) / DEPTH);
        for (int i = 0; i < DEPTH; i++) sorted[i] = ring_slots[i];
        for (int i = 1; i < DEPTH; i++) begin
          key = sorted[i];
          j = i - 1;
          while (j >= 0 && sorted[j] > key) begin
            sorted[j + 1] = sorted[j];
            j--;
          end
          sorted[j + 1] = key;
        end
        r.median_value = 16'((longint'(sorted[DEPTH/2 - 1]) + longint'(sorted[DEPTH/2])) / 2);
      end
      default: ;
    endcase
    r.free_count = ring_free;
    r.write_position = wr_ptr;
    r.read_position = rd_ptr;
    return r;
  endfunction

  // Check each strobed result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result);
      end else begin
        result_t e;
        e = expected_results.pop_front();
        if (result !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", e, result);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Directed table; check_row marks rows whose result is typed in
  typedef struct {
    item_t   stim;
    logic    check_row;
    result_t want;
  } directed_row_t;

  directed_row_t directed_table [$];

  function automatic result_t fixed_result(logic signed [15:0] pv, logic pe,
                                           logic [4:0] fc, logic [3:0] wp, logic [3:0] rp);
    result_t r;
    r = '0;
    r.pop_value = pv;
    r.pop_empty = pe;
    r.free_count = fc;
    r.write_position = wp;
    r.read_position = rp;
    return r;
  endfunction

  function automatic item_t mk(cmd_t c, logic signed [15:0] s);
    item_t it;
    it.command = c;
    it.sample = s;
    return it;
  endfunction

  task automatic build_directed();
    result_t zero_stats;
    zero_stats = fixed_result(-16'sd1, 1'b0, 5'd16, 4'd0, 4'd0);
    directed_table.push_back('{mk(CMD_POP, 16'sd0), 1'b1,
                               fixed_result(-16'sd1, 1'b1, 5'd16, 4'd0, 4'd0)});
    directed_table.push_back('{mk(CMD_STATS, 16'sd0), 1'b1, zero_stats});
    directed_table.push_back('{mk(CMD_PUSH, 16'sh7fff), 1'b1,
                               fixed_result(-16'sd1, 1'b0, 5'd15, 4'd1, 4'd0)});
    directed_table.push_back('{mk(CMD_PUSH, -16'sh8000), 1'b0, zero_stats});
    directed_table.push_back('{mk(CMD_PUSH, -16'sd1), 1'b0, zero_stats});
    directed_table.push_back('{mk(CMD_STATS, 16'sd0), 1'b0, zero_stats});
    directed_table.push_back('{mk(CMD_POP, 16'sd0), 1'b1,
                               fixed_result(16'sh7fff, 1'b0, 5'd14, 4'd3, 4'd1)});
    directed_table.push_back('{mk(CMD_POP, 16'sd0), 1'b0, zero_stats});
    // popped -1 is not empty
    directed_table.push_back('{mk(CMD_POP, 16'sd0), 1'b1,
                               fixed_result(-16'sd1, 1'b0, 5'd16, 4'd3, 4'd3)});
    directed_table.push_back('{item_t'({2'd3, 16'sh5555}), 1'b1,
                               fixed_result(-16'sd1, 1'b0, 5'd16, 4'd3, 4'd3)});
    // fill past full so the read pointer follows the write pointer
    for (int i = 0; i < 18; i++)
      directed_table.push_back('{mk(CMD_PUSH, (i % 2) ? -16'sh8000 : 16'sh7fff), 1'b0, zero_stats});
    directed_table.push_back('{mk(CMD_STATS, 16'sd0), 1'b0, zero_stats});
  endtask

  // Returns at the edge after the accept; busy is always high at that edge
  task automatic send_item(item_t it);
    item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_results.push_back(predict_ring(it));
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_gap();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    repeat (gap) @(posedge clk);
  endtask

  function automatic item_t random_item();
    item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) it.command = CMD_PUSH;
    else if (pick < 85) it.command = CMD_POP;
    else if (pick < 97) it.command = CMD_STATS;
    else it.command = 2'd3;
    case ($urandom_range(0, 4))
      0: it.sample = 16'($urandom_range(0, 3)) - 16'sd1;
      1: it.sample = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
      2: it.sample = 16'($urandom_range(0, 7)) * 16'sd100;
      default: it.sample = 16'($urandom());
    endcase
    return it;
  endfunction

  initial begin
    int burst;
    for (int i = 0; i < DEPTH; i++) ring_slots[i] = '0;
    wr_ptr = '0;
    rd_ptr = '0;
    ring_free = 5'(DEPTH);
    build_directed();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_table[n]) begin
      send_item(directed_table[n].stim);
      if (directed_table[n].check_row && expected_results[$] !== directed_table[n].want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("table row %0d: typed %p predicted %p", n, directed_table[n].want,
                   expected_results[$]);
      end
    end
    for (int n = 0; n < 600; n += burst) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst; b++) send_item(random_item());
      if (n > 300 && n < 330) wait (expected_results.size() == 0);
      random_gap();
    end
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  final if (expected_results.size() != 0) $display("%0d results missing", expected_results.size());
endmodule
`default_nettype wire
